@@ sv/brdma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brdma_pkg
// Shared types and constants for the banked RAM with block copy.
// ----------------------------------------------------------------------------
package brdma_pkg;

  localparam int RAM_BYTES  = 65536;
  localparam int ADDR_W     = 16;
  localparam int BANK_COUNT = 4;
  localparam int BANK_W     = 2;
  localparam int WIN_W      = 14;   // log2(RAM_BYTES / BANK_COUNT)
  localparam int LEN_W      = 17;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_STORE = 2'd1,
    MODE_BANK  = 2'd2,
    MODE_COPY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STORE,
    OP_NOP,
    OP_COPY
  } op_kind_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_RUN,
    BK_COPY,
    BK_FLUSH,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       offset;
    logic [7:0]        store_byte;
    logic [7:0]        bank_number;
    logic [15:0]       copy_dest;
    logic [15:0]       copy_source;
    logic [LEN_W-1:0]  copy_length;
  } brdma_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       applied;
  } brdma_out_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_kind_t          kind;
    logic              ok;
    logic [ADDR_W-1:0] addr;   // physical load/store address
    logic [7:0]        data;
    logic [ADDR_W-1:0] src;    // first source byte of a copy
    logic [ADDR_W-1:0] dst;    // first destination byte of a copy
    logic [ADDR_W-1:0] cnt;    // copy length minus one
    logic              desc;   // copy runs from the top down
  } brdma_cmd_t;

endpackage

@@ sv/brdma_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brdma_front
// Accepts request beats, tracks the current bank and classifies each request.
// ----------------------------------------------------------------------------
module brdma_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  brdma_pkg::brdma_in_t  req,
  input  logic                  clearing,
  input  logic                  q_full,
  output logic                  push,
  output brdma_pkg::brdma_cmd_t cmd
);
  import brdma_pkg::*;

  logic [BANK_W-1:0] current_bank;
  logic              accept;
  logic              bank_ok;
  logic [LEN_W:0]    src_end;
  logic [LEN_W:0]    dst_end;
  logic [LEN_W-1:0]  len_m1;

  assign req_stall = q_full | clearing;
  assign accept    = req_valid & ~req_stall;
  assign push      = accept;

  assign bank_ok = req.bank_number < 8'(BANK_COUNT);
  assign src_end = {2'b00, req.copy_source} + {1'b0, req.copy_length};
  assign dst_end = {2'b00, req.copy_dest} + {1'b0, req.copy_length};
  assign len_m1  = req.copy_length - LEN_W'(1);

  always_comb begin
    cmd      = '0;
    cmd.data = req.store_byte;
    cmd.addr = {current_bank, req.offset[WIN_W-1:0]};
    cmd.cnt  = len_m1[ADDR_W-1:0];
    cmd.desc = req.copy_dest > req.copy_source;
    cmd.src  = cmd.desc ? req.copy_source + cmd.cnt : req.copy_source;
    cmd.dst  = cmd.desc ? req.copy_dest + cmd.cnt : req.copy_dest;
    case (req.mode)
      MODE_LOAD: begin
        cmd.kind = OP_LOAD;
        cmd.ok   = req.offset[ADDR_W-1:WIN_W] == '0;
      end
      MODE_STORE: begin
        cmd.kind = OP_STORE;
        cmd.ok   = req.offset[ADDR_W-1:WIN_W] == '0;
      end
      MODE_BANK: begin
        cmd.kind = OP_NOP;
        cmd.ok   = bank_ok;
      end
      default: begin
        cmd.kind = OP_COPY;
        cmd.ok   = (req.copy_length != '0) && (src_end <= (LEN_W+1)'(RAM_BYTES)) &&
                   (dst_end <= (LEN_W+1)'(RAM_BYTES));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_bank <= '0;
    end else if (accept && req.mode == MODE_BANK && bank_ok) begin
      current_bank <= req.bank_number[BANK_W-1:0];
    end
  end

endmodule

@@ sv/brdma_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brdma_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module brdma_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  brdma_pkg::brdma_cmd_t push_data,
  output logic                  full,
  input  logic                  pop,
  output brdma_pkg::brdma_cmd_t pop_data,
  output logic                  empty
);
  import brdma_pkg::*;

  brdma_cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/brdma_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brdma_back
// Executes commands against the byte RAM, runs the reset clear and block
// copies, and holds the response register.
// ----------------------------------------------------------------------------
module brdma_back (
  input  logic                  clk,
  input  logic                  rst,
  input  brdma_pkg::brdma_cmd_t cmd,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  clearing,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output brdma_pkg::brdma_out_t rsp
);
  import brdma_pkg::*;

  logic [7:0] mem [RAM_BYTES];
  logic [7:0] rdata;

  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] clr_cnt;

  logic [ADDR_W-1:0] src_ptr;
  logic [ADDR_W-1:0] dst_ptr;
  logic [ADDR_W-1:0] cnt;
  logic              desc;
  logic              wr_pend;
  logic [ADDR_W-1:0] cp_waddr;
  logic              copy_start;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic       s1_valid;
  logic       s1_load;
  logic       s1_applied;
  logic       s1_set;
  logic       s1_set_load;
  logic       s1_set_applied;
  logic       s1_move;
  logic       s1_free;
  logic       out_open;

  assign clearing = state == BK_CLEAR;
  assign out_open = ~rsp_valid | ~rsp_stall;
  assign s1_move  = s1_valid & out_open;
  assign s1_free  = ~s1_valid | s1_move;

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = cmd.addr;
    wr_data        = cmd.data;
    rd_en          = 1'b0;
    rd_addr        = cmd.addr;
    s1_set         = 1'b0;
    s1_set_load    = 1'b0;
    s1_set_applied = 1'b0;
    copy_start     = 1'b0;
    case (state)
      BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (&clr_cnt) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (!q_empty && s1_free) begin
          pop = 1'b1;
          case (cmd.kind)
            OP_LOAD: begin
              rd_en          = cmd.ok;
              s1_set         = 1'b1;
              s1_set_load    = cmd.ok;
              s1_set_applied = cmd.ok;
            end
            OP_STORE: begin
              wr_en          = cmd.ok;
              s1_set         = 1'b1;
              s1_set_applied = cmd.ok;
            end
            OP_COPY: begin
              if (cmd.ok) begin
                copy_start = 1'b1;
                state_next = BK_COPY;
              end else begin
                s1_set = 1'b1;
              end
            end
            default: begin
              s1_set         = 1'b1;
              s1_set_applied = cmd.ok;
            end
          endcase
        end
      end
      BK_COPY: begin
        // read one byte ahead, write the byte read last cycle
        rd_en   = 1'b1;
        rd_addr = src_ptr;
        wr_en   = wr_pend;
        wr_addr = cp_waddr;
        wr_data = rdata;
        if (cnt == '0) state_next = BK_FLUSH;
      end
      BK_FLUSH: begin
        wr_en      = 1'b1;
        wr_addr    = cp_waddr;
        wr_data    = rdata;
        state_next = BK_DONE;
      end
      BK_DONE: begin
        if (s1_free) begin
          s1_set         = 1'b1;
          s1_set_applied = 1'b1;
          state_next     = BK_RUN;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (copy_start) begin
      src_ptr <= cmd.src;
      dst_ptr <= cmd.dst;
      cnt     <= cmd.cnt;
      desc    <= cmd.desc;
      wr_pend <= 1'b0;
    end else if (state == BK_COPY) begin
      src_ptr  <= desc ? src_ptr - ADDR_W'(1) : src_ptr + ADDR_W'(1);
      dst_ptr  <= desc ? dst_ptr - ADDR_W'(1) : dst_ptr + ADDR_W'(1);
      cnt      <= cnt - ADDR_W'(1);
      wr_pend  <= 1'b1;
      cp_waddr <= dst_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_set) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_set) begin
      s1_load    <= s1_set_load;
      s1_applied <= s1_set_applied;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_open) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      rsp.read_byte <= s1_load ? rdata : 8'd0;
      rsp.applied   <= s1_applied;
    end
  end

endmodule

@@ sv/banked_ram_with_dma_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_ram_with_dma_top
// Byte RAM in four bank windows with load, store, bank select and block copy.
// ----------------------------------------------------------------------------
// A load, store or bank select is answered through the queue, the s1 stage
//   and the response register; one such request per cycle sustained while no
//   copy runs and responses do not stall. A block copy holds the back end,
//   one RAM byte per cycle through one read and one write port, after which
//   queued requests resume. Reset: synchronous; afterwards the RAM is swept
//   to zero, one byte a cycle, with req_stall held high until it is done.
// ----------------------------------------------------------------------------
module banked_ram_with_dma_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  brdma_pkg::brdma_in_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output brdma_pkg::brdma_out_t rsp
);
  import brdma_pkg::*;

  // front -> queue
  brdma_cmd_t push_cmd;
  logic       push;
  logic       q_full;

  // queue -> back
  brdma_cmd_t head_cmd;
  logic       q_empty;
  logic       pop;

  // back -> front: the reset sweep owns the RAM port
  logic       clearing;

  // Front: owns the current bank, checks windows and copy bounds, and works
  // out physical addresses and copy direction for the back end.
  brdma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // Short queue so the front keeps taking beats while a response stalls.
  brdma_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_cmd),
    .empty     (q_empty)
  );

  // Back: the RAM itself, the copy sequencer and the response register.
  brdma_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ sim/banked_ram_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_ram_checker
// Watches both channels, keeps a shadow RAM and bank register, and checks
// every response beat in order against the shadow's answer.
// ----------------------------------------------------------------------------
module banked_ram_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  brdma_pkg::brdma_in_t  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  brdma_pkg::brdma_out_t rsp,
  output int                    fail_count,
  output int                    pending
);
  import brdma_pkg::*;

  localparam int WIN_BYTES = RAM_BYTES / BANK_COUNT;

  logic [7:0]        shadow_ram [RAM_BYTES];
  logic [BANK_W-1:0] shadow_bank;
  brdma_out_t        due_rsp_q [$];

  // Applies one request to the shadow state and returns its response.
  function automatic brdma_out_t ram_access_result(input brdma_in_t b);
    brdma_out_t  r;
    int unsigned phys;
    int unsigned src;
    int unsigned dst;
    int unsigned len;
    int          k;
    r    = '0;
    phys = int'(shadow_bank) * WIN_BYTES + int'(b.offset);
    case (mode_t'(b.mode))
      MODE_LOAD: begin
        if (b.offset < WIN_BYTES) begin
          r.read_byte = shadow_ram[phys];
          r.applied   = 1'b1;
        end
      end
      MODE_STORE: begin
        if (b.offset < WIN_BYTES) begin
          shadow_ram[phys] = b.store_byte;
          r.applied        = 1'b1;
        end
      end
      MODE_BANK: begin
        if (b.bank_number < BANK_COUNT) begin
          shadow_bank = b.bank_number[BANK_W-1:0];
          r.applied   = 1'b1;
        end
      end
      default: begin
        src = b.copy_source;
        dst = b.copy_dest;
        len = b.copy_length;
        if (len != 0 && src + len <= RAM_BYTES && dst + len <= RAM_BYTES) begin
          // move direction keeps overlapping ranges intact
          if (dst <= src) begin
            for (k = 0; k < int'(len); k++) shadow_ram[dst + k] = shadow_ram[src + k];
          end else begin
            for (k = int'(len) - 1; k >= 0; k--) shadow_ram[dst + k] = shadow_ram[src + k];
          end
          r.applied = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    brdma_out_t want;
    int         a;
    if (rst) begin
      for (a = 0; a < RAM_BYTES; a++) shadow_ram[a] = 8'h00;
      shadow_bank = '0;
      fail_count  = 0;
      due_rsp_q.delete();
    end else begin
      if (req_valid && !req_stall) due_rsp_q.push_back(ram_access_result(req));
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp_q.size() == 0) begin
          $error("response beat with nothing expected: read_byte %0h applied %0b",
                 rsp.read_byte, rsp.applied);
          fail_count++;
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp.read_byte !== want.read_byte) begin
            $error("read_byte: expected %0h, actual %0h", want.read_byte, rsp.read_byte);
            fail_count++;
          end
          if (rsp.applied !== want.applied) begin
            $error("applied: expected %0b, actual %0b", want.applied, rsp.applied);
            fail_count++;
          end
        end
      end
    end
    pending = due_rsp_q.size();
  end

endmodule

@@ sim/banked_ram_with_dma_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_ram_with_dma_top_tb
// Drives load, store, bank select and block copy beats into the banked RAM,
// with random gaps and response stalls, and lets the checker judge results.
// ----------------------------------------------------------------------------
module banked_ram_with_dma_top_tb;
  import brdma_pkg::*;

  localparam int WIN_BYTES     = RAM_BYTES / BANK_COUNT;
  localparam int N_RANDOM      = 1075;
  localparam int CYCLE_LIMIT   = 3000000;  // clear sweep + big copies, with margin
  localparam int HOLD_AT_RSP   = 300;      // response count that starts the long hold
  localparam int LONG_HOLD     = 400;      // cycles of solid response stall
  localparam int DRAIN_AT_ITEM = 700;      // random item before which the sender drains

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  brdma_in_t  req;
  logic       rsp_valid;
  logic       rsp_stall;
  brdma_out_t rsp;

  int          fail_count;
  int          pending;
  int unsigned sent;

  banked_ram_with_dma_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  banked_ram_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost response ends here.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("cycle limit reached with %0d responses outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side. After each accepted beat, draw how long to stall. Every
  // third stretch of 50 beats runs with no stall at all. Once, the stall is
  // held for a long run so the block backs up and pushes back on requests.
  // --------------------------------------------------------------------------
  initial begin : rsp_side
    int unsigned hold_left;
    int unsigned taken;
    rsp_stall = 1'b0;
    hold_left = 0;
    taken     = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        taken++;
        if (taken == HOLD_AT_RSP)     hold_left = LONG_HOLD;
        else if ((taken / 50) % 3 == 1) hold_left = 0;
        else                           hold_left = $urandom_range(0, 5);
      end
      @(negedge clk);
      rsp_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers
  // --------------------------------------------------------------------------

  // Fully random beat; also the filler for fields a mode does not use.
  function automatic brdma_in_t any_beat();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(brdma_in_t)-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Gap drawn per beat, except every fourth stretch of 40 beats is back to back.
  task automatic put_beat(input brdma_in_t b);
    int unsigned gap;
    gap = ((sent / 40) % 4 == 2) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      req_valid <= 1'b0;
      req       <= any_beat();  // junk while idle
      repeat (gap) @(negedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic do_load(input logic [15:0] off);
    brdma_in_t b;
    b        = any_beat();
    b.mode   = MODE_LOAD;
    b.offset = off;
    put_beat(b);
  endtask

  task automatic do_store(input logic [15:0] off, input logic [7:0] data);
    brdma_in_t b;
    b            = any_beat();
    b.mode       = MODE_STORE;
    b.offset     = off;
    b.store_byte = data;
    put_beat(b);
  endtask

  task automatic do_bank(input logic [7:0] num);
    brdma_in_t b;
    b             = any_beat();
    b.mode        = MODE_BANK;
    b.bank_number = num;
    put_beat(b);
  endtask

  task automatic do_copy(input logic [15:0] dst, input logic [15:0] src,
                         input logic [LEN_W-1:0] len);
    brdma_in_t b;
    b             = any_beat();
    b.mode        = MODE_COPY;
    b.copy_dest   = dst;
    b.copy_source = src;
    b.copy_length = len;
    put_beat(b);
  endtask

  // Window offsets bunch at both ends of the window so loads see earlier
  // stores and copies; a few land right at the edge or anywhere at all.
  function automatic logic [15:0] window_offset();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 16'($urandom_range(0, 63));
    if (pick < 80) return 16'($urandom_range(WIN_BYTES - 64, WIN_BYTES - 1));
    if (pick < 88) return pick[0] ? 16'(WIN_BYTES - 1) : 16'(WIN_BYTES);
    return 16'($urandom);
  endfunction

  // Physical address in the same hot zones, any bank.
  function automatic logic [15:0] hot_phys();
    logic [BANK_W-1:0] bk;
    logic [WIN_W-1:0]  lo;
    bk = BANK_W'($urandom_range(0, BANK_COUNT - 1));
    lo = $urandom_range(0, 1) ? WIN_W'($urandom_range(0, 95))
                              : WIN_W'($urandom_range(WIN_BYTES - 96, WIN_BYTES - 1));
    return {bk, lo};
  endfunction

  // Mostly short copies among the hot zones; some mid-size, some that must
  // be refused, and rarely a large one since the block takes a cycle a byte.
  task automatic random_copy();
    int unsigned pick;
    int unsigned len;
    int unsigned edge_addr;
    pick = $urandom_range(0, 199);
    if (pick < 150) begin
      do_copy(hot_phys(), hot_phys(), LEN_W'($urandom_range(1, 48)));
    end else if (pick < 176) begin
      len = $urandom_range(49, 2048);
      do_copy(16'($urandom_range(0, RAM_BYTES - len)),
              16'($urandom_range(0, RAM_BYTES - len)), LEN_W'(len));
    end else if (pick < 198) begin
      case (pick % 3)
        0: do_copy(16'($urandom), 16'($urandom), '0);
        1: do_copy(16'($urandom), 16'($urandom), LEN_W'($urandom));
        default: begin
          // one side runs just past the top of RAM
          edge_addr = RAM_BYTES - $urandom_range(1, 32);
          len       = RAM_BYTES - edge_addr + $urandom_range(1, 16);
          if ($urandom_range(0, 1)) do_copy(16'(edge_addr), 16'd0, LEN_W'(len));
          else                      do_copy(16'd0, 16'(edge_addr), LEN_W'(len));
        end
      endcase
    end else begin
      len = $urandom_range(WIN_BYTES, RAM_BYTES);
      do_copy(16'($urandom_range(0, RAM_BYTES - len)),
              16'($urandom_range(0, RAM_BYTES - len)), LEN_W'(len));
    end
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      do_load(window_offset());
    else if (pick < 65) do_store(window_offset(), 8'($urandom));
    else if (pick < 75) do_bank(8'($urandom_range(0, BANK_COUNT - 1)));
    else if (pick < 77) do_bank(8'($urandom));
    else                random_copy();
  endtask

  // Stop offering and wait until every response so far is back.
  task automatic drain_responses();
    req_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed beats, random beats, drain, verdict.
  // The block sweeps its RAM after reset with req_stall high; the first
  // beat simply waits on the handshake.
  // --------------------------------------------------------------------------
  initial begin : req_side
    int n;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    sent      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load/store at both window ends and beyond, bank 0.
    do_load(16'd0);
    do_store(16'd0, 8'hFF);
    do_store(16'd1, 8'h00);
    do_store(16'(WIN_BYTES - 1), 8'h5A);
    do_load(16'd0);
    do_load(16'(WIN_BYTES - 1));
    do_load(16'(WIN_BYTES));            // first offset past the window
    do_store(16'hFFFF, 8'hC3);          // refused, nothing written
    do_load(16'hFFFF);
    // Top bank, last byte of RAM; bad bank numbers keep bank 3.
    do_bank(8'd3);
    do_store(16'(WIN_BYTES - 1), 8'hFF);
    do_bank(8'(BANK_COUNT));
    do_bank(8'hFF);
    do_load(16'(WIN_BYTES - 1));
    do_bank(8'd0);
    // Copies: empty, past end on either side, overlaps both ways,
    // whole RAM, and lengths that are one too many or all ones.
    do_copy(16'd8, 16'd0, '0);
    do_copy(16'd0, 16'hFFFF, LEN_W'(2));
    do_copy(16'hFFFF, 16'd0, LEN_W'(2));
    do_copy(16'd1, 16'd0, LEN_W'(4));   // destination above source
    do_copy(16'd0, 16'd2, LEN_W'(4));   // destination below source
    do_copy(16'd0, 16'hFFFF, LEN_W'(1));
    do_copy(16'd0, 16'd0, LEN_W'(RAM_BYTES));
    do_copy(16'd1, 16'd0, LEN_W'(RAM_BYTES));
    do_copy(16'd0, 16'd0, '1);
    do_load(16'd0);
    do_load(16'd3);

    for (n = 0; n < N_RANDOM; n++) begin
      if (n == DRAIN_AT_ITEM) drain_responses();
      random_request();
    end

    drain_responses();
    repeat (8) @(posedge clk);  // catch any stray late beat
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
